@@ design/rte_pkg.sv @@
// shared types and constants for the run-length text encoder
// no dependencies; imported by the controller, datapath and top module

package rte_pkg;

    // longest run before a forced split
    localparam logic [15:0] MAX_RUN     = 16'd65535;

    // widths of the run counter and the digit store
    localparam int          LEN_W       = 16;
    localparam int          DIGITS      = 5;
    localparam int          DIG_CNT_W   = 3;

    // divide by ten: q = (v * 52429) >> 19, exact for every 16-bit v
    localparam logic [15:0] DIV10_MUL   = 16'd52429;
    localparam int          DIV10_SHIFT = 19;
    localparam int          QUOT_W      = 2 * LEN_W - DIV10_SHIFT;

    localparam logic [7:0]  ASCII_ZERO  = 8'h30;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_CHECK,
        S_DIV,
        S_CHAR,
        S_DIG
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic load_run;
        logic flush_start;
        logic div_step;
        logic emit_char;
        logic emit_dig;
        logic final_flush;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic in_valid;
        logic run_open;
        logic byte_match;
        logic in_last;
        logic at_limit;
        logic div_last;
        logic out_free;
        logic dig_last;
    } t_sts;

endpackage

@@ design/rte_ctrl.sv @@
// controller state machine for the run-length text encoder
// depends on rte_pkg for the state enum and command/status structs

module rte_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  rte_pkg::t_sts i_sts,
    output rte_pkg::t_cmd o_cmd,
    output logic          o_in_stall
);
    import rte_pkg::*;

    t_state r_state, n_state;
    logic   r_back_eval, n_back_eval;
    logic   r_final, n_final;

    // state and flush bookkeeping registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_back_eval <= 1'b0;
            r_final     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_back_eval <= n_back_eval;
            r_final     <= n_final;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_sts.in_valid) n_state = S_EVAL;
            end
            S_EVAL: begin
                if (i_sts.run_open && !i_sts.byte_match) n_state = S_DIV;
                else                                     n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_sts.at_limit || (i_sts.in_last && i_sts.run_open)) n_state = S_DIV;
                else                                                      n_state = S_IDLE;
            end
            S_DIV: begin
                if (i_sts.div_last) n_state = S_CHAR;
            end
            S_CHAR: begin
                if (i_sts.out_free) n_state = S_DIG;
            end
            S_DIG: begin
                if (i_sts.out_free && i_sts.dig_last) begin
                    n_state = r_back_eval ? S_EVAL : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // commands and flush return/final flags
    always_comb begin
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        n_back_eval = r_back_eval;
        n_final     = r_final;
        o_cmd.final_flush = r_final;
        case (r_state)
            S_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.capture = i_sts.in_valid;
            end
            S_EVAL: begin
                if (i_sts.run_open && !i_sts.byte_match) begin
                    // close the old run first; the new one-byte run may still follow
                    o_cmd.flush_start = 1'b1;
                    n_back_eval       = 1'b1;
                    n_final           = !i_sts.in_last;
                end else begin
                    o_cmd.load_run = 1'b1;
                end
            end
            S_CHECK: begin
                if (i_sts.at_limit || (i_sts.in_last && i_sts.run_open)) begin
                    o_cmd.flush_start = 1'b1;
                    n_back_eval       = 1'b0;
                    n_final           = 1'b1;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            S_CHAR: begin
                o_cmd.emit_char = i_sts.out_free;
            end
            S_DIG: begin
                o_cmd.emit_dig = i_sts.out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

@@ design/rte_dpath.sv @@
// datapath for the run-length text encoder: run state, digit split, output register
// depends on rte_pkg for constants and command/status structs

module rte_dpath (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  rte_pkg::t_cmd i_cmd,
    output rte_pkg::t_sts o_sts,
    input  logic          i_in_valid,
    input  logic [7:0]    i_in_byte,
    input  logic          i_end_of_string,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output logic [7:0]    o_out_byte,
    output logic          o_last_result
);
    import rte_pkg::*;

    logic [7:0]           r_in_byte;
    logic                 r_in_last;
    logic [7:0]           r_held;
    logic [LEN_W-1:0]     r_len;
    logic [LEN_W-1:0]     r_val;
    logic [3:0]           r_dig [0:DIGITS-1];
    logic [DIG_CNT_W-1:0] r_nd;
    logic                 r_out_valid;
    logic [7:0]           r_out_byte;
    logic                 r_out_last;

    logic [2*LEN_W-1:0]   w_prod;
    logic [QUOT_W-1:0]    w_quot;
    logic [LEN_W-1:0]     w_quot10;
    logic [LEN_W-1:0]     w_rem;
    logic [DIG_CNT_W-1:0] w_rd_idx;
    logic                 w_out_free;

    // one decimal digit per step by reciprocal multiply
    assign w_prod   = r_val * DIV10_MUL;
    assign w_quot   = w_prod[2*LEN_W-1:DIV10_SHIFT];
    assign w_quot10 = {w_quot, 3'b000} + {2'b00, w_quot, 1'b0};
    assign w_rem    = r_val - w_quot10;
    assign w_rd_idx = r_nd - DIG_CNT_W'(1);

    assign w_out_free = !r_out_valid || !i_out_stall;

    // input capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in_byte <= i_in_byte;
            r_in_last <= i_end_of_string;
        end
    end

    // open run: byte and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
            r_len  <= '0;
        end else if (i_cmd.flush_start) begin
            r_len <= '0;
        end else if (i_cmd.load_run) begin
            if (r_len != '0 && r_in_byte == r_held) begin
                r_len <= r_len + LEN_W'(1);
            end else begin
                r_held <= r_in_byte;
                r_len  <= LEN_W'(1);
            end
        end
    end

    // digit split, least significant first, read back most significant first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nd <= '0;
        end else if (i_cmd.flush_start) begin
            r_val <= r_len;
            r_nd  <= '0;
        end else if (i_cmd.div_step) begin
            r_dig[r_nd] <= w_rem[3:0];
            r_val       <= LEN_W'(w_quot);
            r_nd        <= r_nd + DIG_CNT_W'(1);
        end else if (i_cmd.emit_dig) begin
            r_nd <= w_rd_idx;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_char) begin
            r_out_valid <= 1'b1;
            r_out_byte  <= r_held;
            r_out_last  <= 1'b0;
        end else if (i_cmd.emit_dig) begin
            r_out_valid <= 1'b1;
            r_out_byte  <= ASCII_ZERO + {4'b0000, r_dig[w_rd_idx]};
            r_out_last  <= i_cmd.final_flush && (r_nd == DIG_CNT_W'(1));
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // status to controller
    always_comb begin
        o_sts.in_valid   = i_in_valid;
        o_sts.run_open   = (r_len != '0);
        o_sts.byte_match = (r_in_byte == r_held);
        o_sts.in_last    = r_in_last;
        o_sts.at_limit   = (r_len >= MAX_RUN);
        o_sts.div_last   = (w_quot == '0) || (r_nd == DIG_CNT_W'(DIGITS - 1));
        o_sts.out_free   = w_out_free;
        o_sts.dig_last   = (r_nd == DIG_CNT_W'(1));
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_last_result = r_out_last;

endmodule

@@ design/rle_text_encoder_top.sv @@
// Run-length text encoder with decimal counts.
// Input channel: one byte per transaction (i_in_valid / o_in_stall), with
// i_end_of_string on the final byte of a string. Output channel: one byte per
// transaction (o_out_valid / i_out_stall): a run's byte, then its count as
// ASCII decimal digits, most significant first; o_last_result marks the final
// byte caused by each input transaction that produces output.
// Runs are split at 65535 bytes.
// Throughput: one input at a time. A byte that only extends a run passes
// through capture, evaluation and the run-limit check. Closing a run adds
// the digit split (a step of the shared divide-by-ten logic per count digit),
// then the run byte and each digit in turn on the single output register; when
// a byte change closes it, the new byte is then evaluated again. Receiver
// stalls add to this. The first result follows the digit split; when the end
// flag or the run limit closes the run, the limit check comes before the split.
// Reset (synchronous, active low) closes any open run without output and
// empties the output register. While the receiver stalls, the output
// register holds its byte and the controller waits.

module rle_text_encoder_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_string,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_last_result
);
    import rte_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // control
    rte_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    // datapath
    rte_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_in_valid      (i_in_valid),
        .i_in_byte       (i_in_byte),
        .i_end_of_string (i_end_of_string),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_byte      (o_out_byte),
        .o_last_result   (o_last_result)
    );

endmodule

@@ design/rte_checker.sv @@
// port-level checks for the run-length text encoder
// depends only on the top-level ports; bound to rle_text_encoder_top below

module rte_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_out_byte,
    input logic       o_last_result
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_out_byte) && $stable(o_last_result))
        else $error("stalled result changed");

    // reset empties the output and opens the input
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("reset did not clear the channels");

    // an accepted input transaction makes the block busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted back to back");

endmodule

bind rle_text_encoder_top rte_checker u_rte_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_out_byte    (o_out_byte),
    .o_last_result (o_last_result)
);
